// File: design/rrqs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the round-robin quantum scheduler.
// No dependencies; used by rrqs_cell and round_robin_quantum_scheduler.

package rrqs_pkg;

    // Number of job slots in the queue and the widths that follow from it.
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Field widths.
    localparam int NAME_W = 8;
    localparam int TIME_W = 16;

    // Operation codes of an input item.
    localparam logic OP_ADD      = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    // Status codes of a result item.
    localparam logic [1:0] STATUS_ADDED = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RAN   = 2'd2;
    localparam logic [1:0] STATUS_IDLE  = 2'd3;

    // One queued job.
    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [TIME_W-1:0] remaining;
    } job_t;

    // Per-cell control: shift toward the head, or load the broadcast job.
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: design/rrqs_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One queue slot of the scheduler's cell chain.
// Depends on rrqs_pkg for job_t and cell_ctrl_t.

module rrqs_cell import rrqs_pkg::*; (
    input  wire logic       aclk,
    input  wire cell_ctrl_t ctrl,
    input  wire job_t       neighbor_job,
    input  wire job_t       load_job,
    output job_t            job
);

    job_t job_reg;
    job_t job_next;

    // A load wins over a shift, so a requeued job lands after the chain moves.
    always_comb begin
        job_next = job_reg;
        if (ctrl.load) begin
            job_next = load_job;
        end else if (ctrl.shift) begin
            job_next = neighbor_job;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
    end

    assign job = job_reg;

endmodule

`default_nettype wire

// File: design/round_robin_quantum_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the round-robin quantum scheduler.
// Depends on rrqs_pkg and instantiates a chain of rrqs_cell slots.

// The scheduler holds up to QUEUE_DEPTH jobs in a chain of cells with the
// oldest job always in the first cell. An add item writes the new job into
// the cell just past the last occupied one. A dispatch item runs the job in
// the first cell, moves every cell one step toward the head, and, if the job
// is not done, writes it back with its reduced time behind the last job. The
// result of each item is registered and appears on the m_ side
// the cycle after acceptance. A new item is accepted in every cycle in which
// the result register is empty or its item is being taken, so the sustained
// rate is one item per cycle when the output side does not stall. The quantum
// register may be written at any idle moment through cfg_wr_en.

module round_robin_quantum_scheduler import rrqs_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Configuration.
    input  wire logic              cfg_wr_en,
    input  wire logic [TIME_W-1:0] cfg_wr_data,
    // Input items.
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_operation,
    input  wire logic [NAME_W-1:0] s_job_name,
    input  wire logic [TIME_W-1:0] s_burst_time,
    // Result items.
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_status,
    output logic [NAME_W-1:0]      m_ran_name,
    output logic [TIME_W-1:0]      m_time_used,
    output logic [TIME_W-1:0]      m_time_left,
    output logic                   m_finished
);

    logic [TIME_W-1:0] quantum_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  count_dec;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic [NAME_W-1:0] ran_name_reg;
    logic [NAME_W-1:0] ran_name_next;
    logic [TIME_W-1:0] time_used_reg;
    logic [TIME_W-1:0] time_used_next;
    logic [TIME_W-1:0] time_left_reg;
    logic [TIME_W-1:0] time_left_next;
    logic              finished_reg;
    logic              finished_next;

    logic              accept;
    logic              full;
    logic              empty;
    logic              fits;
    logic [TIME_W-1:0] left_after;
    logic              load_en;
    logic              shift_en;
    logic [IDX_W-1:0]  load_idx;
    job_t              load_job;
    job_t              head_job;
    job_t              cell_job [QUEUE_DEPTH];

    // Handshake: the result register parts the two sides.
    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Queue status and the head job's slice.
    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty      = (count_reg == '0);
    assign count_dec  = count_reg - CNT_W'(1);
    assign head_job   = cell_job[0];
    assign fits       = (head_job.remaining <= quantum_reg);
    assign left_after = head_job.remaining - quantum_reg;

    // Chain control and next values of the result register.
    always_comb begin
        count_next     = count_reg;
        load_en        = 1'b0;
        shift_en       = 1'b0;
        load_idx       = count_reg[IDX_W-1:0];
        load_job.name      = s_job_name;
        load_job.remaining = s_burst_time;
        out_valid_next = out_valid_reg && !m_ready;
        status_next    = status_reg;
        ran_name_next  = ran_name_reg;
        time_used_next = time_used_reg;
        time_left_next = time_left_reg;
        finished_next  = finished_reg;
        if (accept) begin
            out_valid_next = 1'b1;
            status_next    = STATUS_IDLE;
            ran_name_next  = '0;
            time_used_next = '0;
            time_left_next = '0;
            finished_next  = 1'b0;
            if (s_operation == OP_ADD) begin
                if (full) begin
                    status_next = STATUS_FULL;
                end else begin
                    status_next = STATUS_ADDED;
                    load_en     = 1'b1;
                    count_next  = count_reg + CNT_W'(1);
                end
            end else if (!empty) begin
                status_next   = STATUS_RAN;
                ran_name_next = head_job.name;
                shift_en      = 1'b1;
                if (fits) begin
                    time_used_next = head_job.remaining;
                    finished_next  = 1'b1;
                    count_next     = count_dec;
                end else begin
                    time_used_next     = quantum_reg;
                    time_left_next     = left_after;
                    load_en            = 1'b1;
                    load_idx           = count_dec[IDX_W-1:0];
                    load_job.name      = head_job.name;
                    load_job.remaining = left_after;
                end
            end
        end
    end

    // The cell chain; the last cell takes nothing from beyond the end.
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        cell_ctrl_t ctrl;
        job_t       neighbor;
        assign ctrl.shift = shift_en;
        assign ctrl.load  = load_en && (load_idx == IDX_W'(i));
        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign neighbor = '0;
        end else begin : g_inner
            assign neighbor = cell_job[i+1];
        end
        rrqs_cell u_cell (
            .aclk         (aclk),
            .ctrl         (ctrl),
            .neighbor_job (neighbor),
            .load_job     (load_job),
            .job          (cell_job[i])
        );
    end

    // Control state and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg   <= TIME_W'(4);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                quantum_reg <= cfg_wr_data;
            end
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        status_reg    <= status_next;
        ran_name_reg  <= ran_name_next;
        time_used_reg <= time_used_next;
        time_left_reg <= time_left_next;
        finished_reg  <= finished_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_status    = status_reg;
    assign m_ran_name  = ran_name_reg;
    assign m_time_used = time_used_reg;
    assign m_time_left = time_left_reg;
    assign m_finished  = finished_reg;

    // The job count never passes the queue depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("job count above queue depth");

    // Every accepted item leaves a result in the output register.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> out_valid_reg)
        else $error("accepted item produced no result");

    // Only a dispatched job can be reported as finished.
    a_finish_ran: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && finished_reg |-> status_reg == STATUS_RAN)
        else $error("finished flag without a run");

    // An add to a full queue leaves the count alone.
    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_operation == OP_ADD && full |=> count_reg == $past(count_reg))
        else $error("add on full queue changed the count");

endmodule

`default_nettype wire

// File: dv/round_robin_quantum_scheduler_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the round-robin quantum scheduler.
// Depends on rrqs_pkg and round_robin_quantum_scheduler from the design folder.

import rrqs_pkg::*;

// One result item as the scheduler reports it.
typedef struct packed {
    logic [1:0]        status;
    logic [NAME_W-1:0] ran_name;
    logic [TIME_W-1:0] time_used;
    logic [TIME_W-1:0] time_left;
    logic              finished;
} slice_outcome_t;

// Tracks the job ring as the block should hold it and the outcomes still owed.
class schedule_book;
    logic [NAME_W-1:0] slot_name[QUEUE_DEPTH];
    logic [TIME_W-1:0] slot_time[QUEUE_DEPTH];
    int unsigned       head;
    int unsigned       job_count;
    logic [TIME_W-1:0] quantum;
    slice_outcome_t    pending_outcomes[$];
    int                errors;

    function new();
        head      = 0;
        job_count = 0;
        quantum   = 16'd4;
        errors    = 0;
    endfunction

    function void set_quantum(input logic [TIME_W-1:0] value);
        quantum = value;
    endfunction

    // Apply one accepted item to the ring and queue the outcome it must cause.
    function void log_request(input logic op, input logic [NAME_W-1:0] name,
                              input logic [TIME_W-1:0] burst);
        slice_outcome_t    outcome;
        int unsigned       tail;
        logic [TIME_W-1:0] rem;
        outcome = '0;
        if (op == OP_ADD) begin
            if (job_count >= QUEUE_DEPTH) begin
                outcome.status = STATUS_FULL;
            end else begin
                tail            = (head + job_count) % QUEUE_DEPTH;
                slot_name[tail] = name;
                slot_time[tail] = burst;
                job_count++;
                outcome.status = STATUS_ADDED;
            end
        end else if (job_count == 0) begin
            outcome.status = STATUS_IDLE;
        end else begin
            rem              = slot_time[head];
            outcome.status   = STATUS_RAN;
            outcome.ran_name = slot_name[head];
            if (rem <= quantum) begin
                // The job completes and drops out of the ring.
                outcome.time_used = rem;
                outcome.finished  = 1'b1;
                job_count--;
            end else begin
                // The job goes to the tail; on a full ring that is its own slot.
                tail              = (head + job_count) % QUEUE_DEPTH;
                outcome.time_used = quantum;
                outcome.time_left = rem - quantum;
                slot_name[tail]   = outcome.ran_name;
                slot_time[tail]   = outcome.time_left;
            end
            head = (head + 1) % QUEUE_DEPTH;
        end
        pending_outcomes.push_back(outcome);
    endfunction

    function void compare_field(input string field, input int unsigned want,
                                input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        end
    endfunction

    // Compare one accepted result with the oldest outcome still owed.
    function void check_outcome(input logic [1:0] status, input logic [NAME_W-1:0] ran_name,
                                input logic [TIME_W-1:0] time_used,
                                input logic [TIME_W-1:0] time_left, input logic finished);
        slice_outcome_t want;
        if (pending_outcomes.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, actual status %0d",
                     $time, status);
            errors++;
            return;
        end
        want = pending_outcomes.pop_front();
        if ($isunknown({status, ran_name, time_used, time_left, finished})) begin
            $display("%0t: unknown bits in result, expected %h, actual %h", $time, want,
                     {status, ran_name, time_used, time_left, finished});
            errors++;
            return;
        end
        compare_field("status", 32'(want.status), 32'(status));
        compare_field("ran_name", 32'(want.ran_name), 32'(ran_name));
        compare_field("time_used", 32'(want.time_used), 32'(time_used));
        compare_field("time_left", 32'(want.time_left), 32'(time_left));
        compare_field("finished", 32'(want.finished), 32'(finished));
    endfunction
endclass

module round_robin_quantum_scheduler_test;

    localparam int STALL_LIMIT  = 2000;
    localparam int TARGET_ITEMS = 1050;

    logic              aclk         = 1'b0;
    logic              aresetn      = 1'b0;
    logic              cfg_wr_en    = 1'b0;
    logic [TIME_W-1:0] cfg_wr_data  = '0;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic              s_operation  = OP_ADD;
    logic [NAME_W-1:0] s_job_name   = '0;
    logic [TIME_W-1:0] s_burst_time = '0;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    logic [1:0]        m_status;
    logic [NAME_W-1:0] m_ran_name;
    logic [TIME_W-1:0] m_time_used;
    logic [TIME_W-1:0] m_time_left;
    logic              m_finished;

    schedule_book sb;
    logic         sender_gappy = 1'b0;
    logic         sink_busy    = 1'b0;
    int           items_sent   = 0;
    int           quiet_cycles = 0;

    round_robin_quantum_scheduler u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_job_name  (s_job_name),
        .s_burst_time(s_burst_time),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_ran_name  (m_ran_name),
        .m_time_used (m_time_used),
        .m_time_left (m_time_left),
        .m_finished  (m_finished)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Idle length: mostly none, sometimes a few cycles, rarely a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one item from a falling edge and hold it until it is accepted.
    task automatic send_item(input logic op, input logic [NAME_W-1:0] name,
                             input logic [TIME_W-1:0] burst);
        int gap;
        gap = sender_gappy ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_job_name   <= name;
        s_burst_time <= burst;
        do @(posedge aclk); while (!s_ready);
        sb.log_request(op, name, burst);
        items_sent++;
        @(negedge aclk);
    endtask

    // Stop sending and wait until every owed result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending_outcomes.size() != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_quantum(input logic [TIME_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_quantum(value);
    endtask

    // Result side: stalls in some stretches, always ready in others.
    initial begin : result_sink
        int stall_left;
        int cyc;
        int g;
        stall_left = 0;
        cyc        = 0;
        forever begin
            @(negedge aclk);
            cyc++;
            if (cyc % 256 == 0) sink_busy = ($urandom_range(0, 2) != 0);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (sink_busy) begin
                g = pick_gap();
                if (g > 0) begin
                    m_ready    <= 1'b0;
                    stall_left = g - 1;
                end else begin
                    m_ready <= 1'b1;
                end
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Check every result item taken by the sink.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_outcome(m_status, m_ran_name, m_time_used, m_time_left, m_finished);
        end
    end

    // End the run if nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        int                phase;
        int                phase_len;
        int                r;
        int                add_pct;
        logic [TIME_W-1:0] q;
        logic [TIME_W-1:0] burst;
        sb = new();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part with the reset quantum of 4.
        send_item(OP_DISPATCH, 8'h3C, 16'h1234);     // empty queue reports idle
        send_item(OP_ADD, 8'h00, 16'h0000);          // zero burst time
        send_item(OP_ADD, 8'hFF, 16'hFFFF);
        send_item(OP_ADD, 8'hA5, 16'd4);             // burst equal to the quantum
        send_item(OP_ADD, 8'h5A, 16'd9);
        repeat (5) send_item(OP_DISPATCH, NAME_W'($urandom_range(0, 255)),
                             TIME_W'($urandom_range(0, 65535)));
        for (int i = 0; i < 14; i++) begin
            send_item(OP_ADD, NAME_W'(16 + i), TIME_W'(i));
        end
        send_item(OP_ADD, 8'hEE, 16'd7);             // add on a full queue
        send_item(OP_DISPATCH, 8'h00, 16'h0000);     // requeue while full
        send_item(OP_DISPATCH, 8'hFF, 16'hFFFF);

        // Random phases, each with its own quantum and idling pattern.
        phase = 0;
        while (items_sent < TARGET_ITEMS) begin
            case (phase)
                0: q = '0;
                1: q = '1;
                2: q = 16'd1;
                default: begin
                    r = $urandom_range(0, 9);
                    if (r < 6) q = TIME_W'($urandom_range(1, 8));
                    else if (r < 8) q = TIME_W'($urandom_range(1, 65535));
                    else if (r < 9) q = '1;
                    else q = 16'd1;
                end
            endcase
            write_quantum(q);
            sender_gappy = ($urandom_range(0, 3) != 0);
            phase_len    = (phase == 0) ? 40 : $urandom_range(40, 120);
            for (int k = 0; k < phase_len; k++) begin
                // Hold back until the block has answered everything.
                if (phase % 3 == 0 && k == phase_len / 2) drain_results();
                if (sb.job_count == 0) add_pct = 75;
                else if (sb.job_count >= QUEUE_DEPTH) add_pct = 25;
                else add_pct = 50;
                if ($urandom_range(0, 99) < add_pct) begin
                    r = $urandom_range(0, 99);
                    if (r < 10) burst = '0;
                    else if (r < 15) burst = '1;
                    else if (r < 70) burst = TIME_W'($urandom_range(0, 40));
                    else burst = TIME_W'($urandom_range(0, 65535));
                    send_item(OP_ADD, NAME_W'($urandom_range(0, 255)), burst);
                end else begin
                    send_item(OP_DISPATCH, NAME_W'($urandom_range(0, 255)),
                              TIME_W'($urandom_range(0, 65535)));
                end
            end
            phase++;
        end

        // Let the last results come back, then a few more cycles.
        drain_results();
        repeat (10) @(negedge aclk);
        if (sb.pending_outcomes.size() != 0) begin
            $display("%0t: results missing, expected %0d more, actual 0", $time,
                     sb.pending_outcomes.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
